FILE: rtl/core/bprp_pkg.sv
// shared types and constants for the reversed-digit prime pair check
package bprp_pkg;

	// width of the reversed_value result field
	localparam int unsigned REV_BITS = 20;
	// reversed number needs at most this many bits beyond the input width
	localparam int unsigned EXTRA_BITS = 4;

	localparam logic [3:0] RADIX_MIN   = 4'd2;
	localparam logic [3:0] RADIX_MAX   = 4'd10;
	localparam logic [3:0] RADIX_RESET = 4'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic div_start;
		logic div_trial;
		logic rev_update;
		logic cand_load;
		logic which_rev;
		logic trial_step;
		logic mark_prime;
		logic mark_comp;
		logic publish;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic n_zero;
		logic div_done;
		logic cand_small;
		logic sq_gt;
		logic rem_zero;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/core/bprp_div.sv
// iterative restoring divider, one quotient bit per cycle
module bprp_div #(
	parameter int unsigned WIDTH = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder
);

	localparam int unsigned CNT_W = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[WIDTH-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/core/bprp_datapath.sv
// datapath: radix register, digit reversal, trial division and result register
module bprp_datapath
	import bprp_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               st,
	input  logic                  cfg_valid,
	input  logic [3:0]            cfg_data,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  result_stall,
	output logic                  result_valid,
	output logic [REV_BITS-1:0]   reversed_value,
	output logic                  value_is_prime,
	output logic                  reversed_is_prime,
	output logic                  pair_found
);

	localparam int unsigned REV_W = VALUE_BITS + EXTRA_BITS;

	logic [3:0]            radix_q;
	logic [3:0]            eff_radix;
	logic [VALUE_BITS-1:0] val_q;
	logic [REV_W-1:0]      n_q;
	logic [REV_W-1:0]      rev_q;
	logic [REV_W-1:0]      cand_q;
	logic [REV_W-1:0]      d_q;
	logic [REV_W:0]        sq_q;
	logic                  vp_q;
	logic                  rp_q;
	logic                  res_valid_q;
	logic [REV_W-1:0]      res_rev_q;
	logic                  res_vp_q;
	logic                  res_rp_q;
	logic [REV_W+3:0]      rev_scaled;
	logic [REV_W-1:0]      div_a;
	logic [REV_W-1:0]      div_b;
	logic                  div_done;
	logic [REV_W-1:0]      div_quo;
	logic [REV_W-1:0]      div_rem;

	always_comb begin
		if (radix_q < RADIX_MIN) begin
			eff_radix = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			eff_radix = RADIX_MAX;
		end else begin
			eff_radix = radix_q;
		end
	end

	assign div_a = cmd.div_trial ? cand_q : n_q;
	assign div_b = cmd.div_trial ? d_q : REV_W'(eff_radix);

	bprp_div #(
		.WIDTH(REV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign rev_scaled = rev_q * eff_radix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				radix_q <= cfg_data;
			end
			if (cmd.publish) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value;
			n_q   <= REV_W'(value);
			rev_q <= '0;
		end
		if (cmd.rev_update) begin
			rev_q <= rev_scaled[REV_W-1:0] + div_rem;
			n_q   <= div_quo;
		end
		if (cmd.cand_load) begin
			cand_q <= cmd.which_rev ? rev_q : REV_W'(val_q);
			d_q    <= REV_W'(2);
			sq_q   <= (REV_W + 1)'(4);
		end
		// (d+1)^2 = d^2 + 2d + 1
		if (cmd.trial_step) begin
			sq_q <= sq_q + {d_q, 1'b1};
			d_q  <= d_q + REV_W'(1);
		end
		if (cmd.mark_prime || cmd.mark_comp) begin
			if (cmd.which_rev) begin
				rp_q <= cmd.mark_prime;
			end else begin
				vp_q <= cmd.mark_prime;
			end
		end
		if (cmd.publish) begin
			res_rev_q <= rev_q;
			res_vp_q  <= vp_q;
			res_rp_q  <= rp_q;
		end
	end

	assign st.n_zero     = (n_q == '0);
	assign st.div_done   = div_done;
	assign st.cand_small = (cand_q <= REV_W'(1));
	assign st.sq_gt      = (sq_q > {1'b0, cand_q});
	assign st.rem_zero   = (div_rem == '0);
	assign st.out_free   = !res_valid_q || !result_stall;

	assign result_valid      = res_valid_q;
	assign reversed_value    = REV_BITS'(res_rev_q);
	assign value_is_prime    = res_vp_q;
	assign reversed_is_prime = res_rp_q;
	assign pair_found        = res_vp_q && res_rp_q;

endmodule

FILE: rtl/core/bprp_ctrl.sv
// controller: sequences digit reversal and the two trial-division tests
module bprp_ctrl
	import bprp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		IDLE,
		REV_CHECK,
		REV_WAIT,
		P_INIT,
		P_CHECK,
		P_WAIT,
		PUB
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   which_q;
	logic   decided;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		decided = 1'b0;
		unique case (state_q)
			IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = REV_CHECK;
				end
			end
			REV_CHECK: begin
				if (st.n_zero) begin
					state_d = P_INIT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = REV_WAIT;
				end
			end
			REV_WAIT: begin
				if (st.div_done) begin
					cmd.rev_update = 1'b1;
					state_d        = REV_CHECK;
				end
			end
			P_INIT: begin
				cmd.cand_load = 1'b1;
				state_d       = P_CHECK;
			end
			P_CHECK: begin
				if (st.cand_small) begin
					cmd.mark_comp = 1'b1;
					decided       = 1'b1;
				end else if (st.sq_gt) begin
					cmd.mark_prime = 1'b1;
					decided        = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_trial = 1'b1;
					state_d       = P_WAIT;
				end
			end
			P_WAIT: begin
				// divider operands must stay on the trial side while it runs
				cmd.div_trial = 1'b1;
				if (st.div_done) begin
					if (st.rem_zero) begin
						cmd.mark_comp = 1'b1;
						decided       = 1'b1;
					end else begin
						cmd.trial_step = 1'b1;
						state_d        = P_CHECK;
					end
				end
			end
			PUB: begin
				if (st.out_free) begin
					cmd.publish = 1'b1;
					state_d     = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
		cmd.which_rev = which_q;
		if (decided) begin
			state_d = which_q ? PUB : P_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			which_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				which_q <= 1'b0;
			end else if (decided) begin
				which_q <= 1'b1;
			end
		end
	end

	assign item_stall = (state_q != IDLE);

endmodule

FILE: rtl/core/base_reversed_prime_pair_check.sv
// Reversed-digit prime pair check. One value at a time: its digits in the configured radix
// (2..10, register values outside clamp to the nearest end) are reversed and read back, then
// the value and the reversed number are each tested by trial division with divisors 2, 3, ...
// until the divisor squared exceeds the candidate. Every division runs on one shared restoring
// divider of W = VALUE_BITS+4 bits: one division per radix digit, then one per trial
// divisor for each of the two tests. A finished result waits in an output register, so the
// next value is taken while it is held. The radix register is written through a separate
// port that is always ready and should change only while idle.
module base_reversed_prime_pair_check
	import bprp_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [3:0]            cfg_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [REV_BITS-1:0]   reversed_value,
	output logic                  value_is_prime,
	output logic                  reversed_is_prime,
	output logic                  pair_found
);

	cmd_t    cmd;
	status_t st;

	assign cfg_ready = 1'b1;

	bprp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.st        (st),
		.cmd       (cmd)
	);

	bprp_datapath #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.cfg_valid        (cfg_valid),
		.cfg_data         (cfg_data),
		.value            (value),
		.result_stall     (result_stall),
		.result_valid     (result_valid),
		.reversed_value   (reversed_value),
		.value_is_prime   (value_is_prime),
		.reversed_is_prime(reversed_is_prime),
		.pair_found       (pair_found)
	);

endmodule

FILE: rtl/core/bprp_checker.sv
// port-level checks for the reversed-digit prime pair check, bound to the top level
module bprp_checker
	import bprp_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [3:0]            cfg_data,
	input logic                  item_valid,
	input logic                  item_stall,
	input logic [VALUE_BITS-1:0] value,
	input logic                  result_valid,
	input logic                  result_stall,
	input logic [REV_BITS-1:0]   reversed_value,
	input logic                  value_is_prime,
	input logic                  reversed_is_prime,
	input logic                  pair_found
);

	// a stalled result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(reversed_value))
		else $error("stalled result changed");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pair_found == (value_is_prime && reversed_is_prime))
		else $error("pair flag disagrees with prime flags");

	// one item in flight: busy right after a transaction on the input
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not stalled after transaction");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> !$rose(result_valid))
		else $error("result appeared one cycle after input transaction");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind base_reversed_prime_pair_check bprp_checker #(.VALUE_BITS(VALUE_BITS)) u_bprp_checker (.*);

FILE: test/tb_base_reversed_prime_pair_check.sv
// self-checking testbench for the reversed-digit prime pair check
`timescale 1ns / 1ps

module tb_base_reversed_prime_pair_check;
	import bprp_pkg::*;

	localparam int unsigned VAL_W = 16;
	localparam int unsigned DIR_ROWS = 25;

	typedef struct packed {
		logic [REV_BITS-1:0] rev;
		logic                vp;
		logic                rp;
		logic                pf;
	} pair_t;

	typedef struct {
		logic [3:0]       radix;
		logic [VAL_W-1:0] val;
		bit               typed;
		pair_t            res;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [3:0]          cfg_data;
	logic                item_valid;
	logic                item_stall;
	logic [VAL_W-1:0]    value;
	logic                result_valid;
	logic                result_stall;
	logic [REV_BITS-1:0] reversed_value;
	logic                value_is_prime;
	logic                reversed_is_prime;
	logic                pair_found;

	pair_t       expected_pairs[$];
	pair_t       head_pair;
	dir_row_t    dir_rows [DIR_ROWS];
	logic [3:0]  radix_shadow;
	int          send_idle;
	int          recv_idle;
	int          hold_left;
	int unsigned error_count;
	int unsigned values_sent;
	int unsigned results_checked;
	int unsigned radix_writes;
	int unsigned pairs_seen;

	base_reversed_prime_pair_check #(
		.VALUE_BITS(VAL_W)
	) u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.value             (value),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.reversed_value    (reversed_value),
		.value_is_prime    (value_is_prime),
		.reversed_is_prime (reversed_is_prime),
		.pair_found        (pair_found)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit trial_prime(input longint unsigned n);
		longint unsigned d;
		if (n <= 1) begin
			return 1'b0;
		end
		for (d = 2; d * d <= n; d++) begin
			if (n % d == 0) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic pair_t reverse_and_test(input logic [VAL_W-1:0] v, input logic [3:0] r);
		longint unsigned base;
		longint unsigned n;
		longint unsigned rev;
		pair_t p;
		if (r < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = r;
		end
		n = v;
		rev = 0;
		while (n != 0) begin
			rev = rev * base + n % base;
			n = n / base;
		end
		p.rev = rev[REV_BITS-1:0];
		p.vp = trial_prime(v);
		p.rp = trial_prime(rev);
		p.pf = p.vp && p.rp;
		return p;
	endfunction

	// mostly small values keep trial division short; the rest span all 16 bits
	function automatic logic [VAL_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 72) begin
			return VAL_W'($urandom_range(1023));
		end else if (roll < 80) begin
			return VAL_W'(16'hFFFF - $urandom_range(255));
		end
		return VAL_W'($urandom_range(16'hFFFF));
	endfunction

	// called just after a falling edge, returns just after a falling edge
	task automatic offer_value(input logic [VAL_W-1:0] v, input pair_t res);
		while ($urandom_range(99) < send_idle) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		value = v;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		expected_pairs.insert(expected_pairs.size(), res);
		values_sent++;
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic wait_drained();
		item_valid = 1'b0;
		while (expected_pairs.size() != 0) @(negedge clk);
	endtask

	task automatic write_radix(input logic [3:0] r);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_data = r;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		radix_shadow = r;
		radix_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_random(input int n_items);
		logic [VAL_W-1:0] v;
		for (int i = 0; i < n_items; i++) begin
			if (i % 15 == 14) begin
				write_radix(4'($urandom_range(15)));
			end
			v = pick_value();
			offer_value(v, reverse_and_test(v, radix_shadow));
		end
	endtask

	// receiver: random stall, or a counted hold-off when one is requested
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall = 1'b1;
				hold_left--;
			end else begin
				result_stall = ($urandom_range(99) < recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_pairs.size() == 0) begin
				$error("result transaction with no expectation waiting");
				error_count++;
			end else begin
				head_pair = expected_pairs.pop_front();
				results_checked++;
				if (head_pair.pf) begin
					pairs_seen++;
				end
				if (reversed_value !== head_pair.rev) begin
					$error("reversed_value: expected %0d, got %0d", head_pair.rev,
						reversed_value);
					error_count++;
				end
				if (value_is_prime !== head_pair.vp) begin
					$error("value_is_prime: expected %0d, got %0d", head_pair.vp,
						value_is_prime);
					error_count++;
				end
				if (reversed_is_prime !== head_pair.rp) begin
					$error("reversed_is_prime: expected %0d, got %0d", head_pair.rp,
						reversed_is_prime);
					error_count++;
				end
				if (pair_found !== head_pair.pf) begin
					$error("pair_found: expected %0d, got %0d", head_pair.pf, pair_found);
					error_count++;
				end
			end
		end
	end

	// generous ceiling: every item at its slowest with heavy stalling, several times over
	initial begin
		#100_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int drain_limit;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		item_valid = 1'b0;
		value = '0;
		send_idle = 0;
		recv_idle = 0;
		hold_left = 0;
		error_count = 0;
		values_sent = 0;
		results_checked = 0;
		radix_writes = 0;
		pairs_seen = 0;
		radix_shadow = RADIX_RESET;

		// rows without typed results are left to the predictor
		dir_rows = '{
			'{4'd2,  16'd0,     1'b1, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd2,  16'd1,     1'b1, '{20'd1,     1'b0, 1'b0, 1'b0}},
			'{4'd2,  16'd2,     1'b1, '{20'd1,     1'b1, 1'b0, 1'b0}},
			'{4'd2,  16'd3,     1'b1, '{20'd3,     1'b1, 1'b1, 1'b1}},
			'{4'd2,  16'd11,    1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd2,  16'd32768, 1'b1, '{20'd1,     1'b0, 1'b0, 1'b0}},
			'{4'd2,  16'd65535, 1'b1, '{20'd65535, 1'b0, 1'b0, 1'b0}},
			'{4'd0,  16'd13,    1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd0,  16'd6,     1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd1,  16'd2,     1'b1, '{20'd1,     1'b1, 1'b0, 1'b0}},
			'{4'd10, 16'd13,    1'b1, '{20'd31,    1'b1, 1'b1, 1'b1}},
			'{4'd10, 16'd0,     1'b1, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd10, 16'd1000,  1'b1, '{20'd1,     1'b0, 1'b0, 1'b0}},
			'{4'd10, 16'd65535, 1'b1, '{20'd53556, 1'b0, 1'b0, 1'b0}},
			'{4'd10, 16'd65521, 1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd15, 16'd97,    1'b1, '{20'd79,    1'b1, 1'b1, 1'b1}},
			'{4'd11, 16'd107,   1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd11, 16'd10007, 1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd3,  16'd65535, 1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd9,  16'd80,    1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd5,  16'd7919,  1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd7,  16'd12345, 1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd4,  16'd4096,  1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd6,  16'd997,   1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}},
			'{4'd8,  16'd2,     1'b0, '{20'd0,     1'b0, 1'b0, 1'b0}}
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// first rows run on the reset radix without a write
		foreach (dir_rows[i]) begin
			if (dir_rows[i].radix != radix_shadow) begin
				write_radix(dir_rows[i].radix);
			end
			offer_value(dir_rows[i].val, dir_rows[i].typed ? dir_rows[i].res :
				reverse_and_test(dir_rows[i].val, radix_shadow));
		end

		send_idle = 28;
		recv_idle = 87;
		write_radix(RADIX_MAX);
		run_random(45);

		send_idle = 87;
		recv_idle = 28;
		write_radix(4'd15);
		run_random(20);
		// sender pauses until every result is back
		wait_drained();
		write_radix(4'd0);
		run_random(25);

		send_idle = 0;
		recv_idle = 0;
		write_radix(4'($urandom_range(RADIX_MIN, RADIX_MAX)));
		// long receiver hold-off with short items so the block backs up onto its input
		hold_left = 3000;
		for (int i = 0; i < 6; i++) begin
			value = VAL_W'($urandom_range(63));
			offer_value(value, reverse_and_test(value, radix_shadow));
		end
		run_random(20);

		item_valid = 1'b0;
		while (expected_pairs.size() != 0) @(negedge clk);
		drain_limit = 200;
		repeat (drain_limit) @(negedge clk);
		if (expected_pairs.size() != 0) begin
			$error("%0d expected results never arrived", expected_pairs.size());
			error_count++;
		end

		$display("checked %0d results from %0d values, %0d prime pairs, %0d radix writes",
			results_checked, values_sent, pairs_seen, radix_writes);
		$display("radix register 0..15, idling on each side in turn, one long output hold-off");
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
